// ----- sv/bta_pkg.sv -----
// Shared constants and types for the bounding-box track associator.
package bta_pkg;
  localparam int MaxTracks  = 16;
  localparam int CoordBits  = 12;
  localparam int SlotBits   = $clog2(MaxTracks);
  localparam int CountBits  = $clog2(MaxTracks + 1);
  localparam int IdBits     = 16;
  localparam int MissBits   = 8;
  localparam int KindBits   = 3;

  localparam logic [KindBits-1:0] KIND_JOIN    = 3'd0;
  localparam logic [KindBits-1:0] KIND_NEW     = 3'd1;
  localparam logic [KindBits-1:0] KIND_DROP    = 3'd2;
  localparam logic [KindBits-1:0] KIND_FINISH  = 3'd3;
  localparam logic [KindBits-1:0] KIND_NONE    = 3'd4;

  localparam logic [MissBits-1:0] LIMIT_RESET  = 8'd8;

  typedef struct packed {
    logic [CoordBits-1:0] min_x;
    logic [CoordBits-1:0] min_y;
    logic [CoordBits-1:0] max_x;
    logic [CoordBits-1:0] max_y;
  } box_t;

  typedef struct packed {
    box_t                 box;
    logic [IdBits-1:0]    id;
    logic [MissBits-1:0]  missing;
    logic                 hit;
  } slot_t;
endpackage

// ----- sv/bta_match_unit.sv -----
// Shared compare unit: tests one region against one track box.
module bta_match_unit (
  input  bta_pkg::box_t region_i,
  input  bta_pkg::box_t track_i,
  output logic          match_o
);
  // Any region edge inside the track's range on its axis
  always_comb begin
    match_o = (region_i.min_x >= track_i.min_x && region_i.min_x <= track_i.max_x) ||
              (region_i.min_y >= track_i.min_y && region_i.min_y <= track_i.max_y) ||
              (region_i.max_x >= track_i.min_x && region_i.max_x <= track_i.max_x) ||
              (region_i.max_y >= track_i.min_y && region_i.max_y <= track_i.max_y);
  end
endmodule

// ----- sv/bbox_track_associator.sv -----
// Top level of the bounding-box track associator: table, sequencer, result port.
//
// Usage: drive operation_i and the box fields with start_i high while busy_o
// is low; that edge accepts the transaction. busy_o then stays high while the
// table is walked. Each result is shown for one cycle with valid_o high, and
// last_o marks the final result of the transaction. The final result always
// shows in the first cycle with busy_o low. The receiver cannot stall the block.
// A region walks the table one slot per cycle through one shared compare unit.
// busy_o stays high until a match in a slot joins the region, a free slot
// takes it as a new track, or a full table drops it. A frame end ages all
// tracks, then visits each slot in turn (a finished track closes up the table
// in the cycle it is found), then gives one closing result. Each finish is
// held back one step, so its result shows when the next finish is found or
// in the closing result with last_o.
// Items are sequential: the next transaction is taken once busy_o is low.
// The table is 16 slots of registers; slots close up by shifting. Reset empties
// the table, clears the id counter and sets the missing limit to 8. The user
// must write the limit via cfg_we_i/cfg_data_i only while idle; it is unchecked.
module bbox_track_associator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            operation_i,
  input  logic [bta_pkg::CoordBits-1:0]   box_min_x_i,
  input  logic [bta_pkg::CoordBits-1:0]   box_min_y_i,
  input  logic [bta_pkg::CoordBits-1:0]   box_max_x_i,
  input  logic [bta_pkg::CoordBits-1:0]   box_max_y_i,
  input  logic                            cfg_we_i,
  input  logic [bta_pkg::MissBits-1:0]    cfg_data_i,
  output logic                            valid_o,
  output logic [bta_pkg::KindBits-1:0]    kind_o,
  output logic [bta_pkg::IdBits-1:0]      track_number_o,
  output logic [bta_pkg::CoordBits-1:0]   out_min_x_o,
  output logic [bta_pkg::CoordBits-1:0]   out_min_y_o,
  output logic [bta_pkg::CoordBits-1:0]   out_max_x_o,
  output logic [bta_pkg::CoordBits-1:0]   out_max_y_o,
  output logic                            last_o
);
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_AGE    = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;

  logic [2:0] state_q, state_d;
  bta_pkg::slot_t slot_q [bta_pkg::MaxTracks];
  bta_pkg::slot_t slot_d [bta_pkg::MaxTracks];
  logic [bta_pkg::CountBits-1:0] count_q, count_d;
  logic [bta_pkg::CountBits-1:0] idx_q, idx_d;
  logic [bta_pkg::SlotBits-1:0]  sel;
  logic [bta_pkg::IdBits-1:0]    next_id_q, next_id_d;
  logic [bta_pkg::MissBits-1:0]  limit_q;
  bta_pkg::box_t region_q, region_d;
  logic match;

  // Finish result held until the next one or the end of the walk
  logic                          pend_q, pend_d;
  logic [bta_pkg::IdBits-1:0]    pnum_q, pnum_d;
  bta_pkg::box_t                 pbox_q, pbox_d;

  logic                          valid_d, last_d, valid_q, last_q;
  logic [bta_pkg::KindBits-1:0]  kind_d, okind_q;
  logic [bta_pkg::IdBits-1:0]    num_d, onum_q;
  bta_pkg::box_t                 obox_d, obox_q;

  assign sel = idx_q[bta_pkg::SlotBits-1:0];

  bta_match_unit u_match (
    .region_i (region_q),
    .track_i  (slot_q[sel].box),
    .match_o  (match)
  );

  assign busy_o = (state_q != ST_IDLE);

  // Sequencer and table update
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    count_d   = count_q;
    idx_d     = idx_q;
    next_id_d = next_id_q;
    region_d  = region_q;
    pend_d    = pend_q;
    pnum_d    = pnum_q;
    pbox_d    = pbox_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    kind_d    = bta_pkg::KIND_NONE;
    num_d     = '0;
    obox_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          region_d  = {box_min_x_i, box_min_y_i, box_max_x_i, box_max_y_i};
          idx_d     = '0;
          state_d   = operation_i ? ST_AGE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < count_q && match) begin
          slot_d[sel].box = region_q;
          slot_d[sel].hit = 1'b1;
          valid_d = 1'b1; last_d = 1'b1; kind_d = bta_pkg::KIND_JOIN;
          num_d   = slot_q[sel].id; obox_d = region_q;
          state_d = ST_IDLE;
        end else if (idx_q >= count_q) begin
          valid_d = 1'b1; last_d = 1'b1; obox_d = region_q;
          if (count_q == bta_pkg::CountBits'(bta_pkg::MaxTracks)) begin
            kind_d = bta_pkg::KIND_DROP;
          end else begin
            kind_d = bta_pkg::KIND_NEW;
            num_d  = next_id_q;
            slot_d[count_q[bta_pkg::SlotBits-1:0]] = '{region_q, next_id_q, '0, 1'b0};
            count_d   = count_q + 1'b1;
            next_id_d = next_id_q + 1'b1;
          end
          state_d = ST_IDLE;
        end else if (idx_q == bta_pkg::CountBits'(bta_pkg::MaxTracks - 1)) begin
          valid_d = 1'b1; last_d = 1'b1; obox_d = region_q;
          kind_d  = bta_pkg::KIND_DROP;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_AGE: begin
        // Age all tracks in parallel (independent lanes)
        for (int i = 0; i < bta_pkg::MaxTracks; i++) begin
          if (slot_q[i].hit) slot_d[i].missing = 8'd1;
          else if (slot_q[i].missing != 8'hFF) slot_d[i].missing = slot_q[i].missing + 1'b1;
          slot_d[i].hit = 1'b0;
        end
        idx_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (idx_q >= count_q) begin
          // Walk done: release the held finish, or report none finished
          valid_d = 1'b1; last_d = 1'b1;
          if (pend_q) begin
            kind_d = bta_pkg::KIND_FINISH;
            num_d  = pnum_q; obox_d = pbox_q;
            pend_d = 1'b0;
          end else begin
            kind_d = bta_pkg::KIND_NONE;
          end
          state_d = ST_IDLE;
        end else if (slot_q[sel].missing >= limit_q) begin
          // Emit the previously held finish and hold this one
          if (pend_q) begin
            valid_d = 1'b1; kind_d = bta_pkg::KIND_FINISH;
            num_d   = pnum_q; obox_d = pbox_q;
          end
          pend_d = 1'b1;
          pnum_d = slot_q[sel].id;
          pbox_d = slot_q[sel].box;
          // Close up the table behind this slot
          for (int i = 0; i < bta_pkg::MaxTracks - 1; i++) begin
            if (i >= int'(idx_q)) slot_d[i] = slot_q[i+1];
          end
          slot_d[bta_pkg::MaxTracks-1].hit = 1'b0;
          count_d = count_q - 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      next_id_q <= '0;
      limit_q   <= bta_pkg::LIMIT_RESET;
      pend_q    <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      for (int i = 0; i < bta_pkg::MaxTracks; i++) slot_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      next_id_q <= next_id_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
      pend_q    <= pend_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
      slot_q    <= slot_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    pnum_q   <= pnum_d;
    pbox_q   <= pbox_d;
    okind_q  <= kind_d;
    onum_q   <= num_d;
    obox_q   <= obox_d;
  end

  assign valid_o        = valid_q;
  assign last_o         = last_q;
  assign kind_o         = okind_q;
  assign track_number_o = onum_q;
  assign out_min_x_o    = obox_q.min_x;
  assign out_min_y_o    = obox_q.min_y;
  assign out_max_x_o    = obox_q.max_x;
  assign out_max_y_o    = obox_q.max_y;
endmodule

// ----- sv/bta_checker.sv -----
// Port-level checker for the track associator, bound to the top level.
module bta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       last_o,
  input logic [2:0] kind_o
);
  // Last only travels with a result
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without result");
  // A result's kind is never above kind none
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (kind_o <= bta_pkg::KIND_NONE)) else $error("bad kind");
  // Accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy after start");
endmodule

bind bbox_track_associator bta_checker u_bta_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .valid_o(valid_o), .last_o(last_o), .kind_o(kind_o)
);
